>>> hw/rtl/bsc_pkg.sv
// Shared types, codes and default sizes for the banker's safety check block.
package bsc_pkg;

  localparam int unsigned MAX_PROCS_DEF  = 16;
  localparam int unsigned MAX_RES_DEF    = 8;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Request command codes (s_tuser)
  localparam logic [1:0] CMD_LOAD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_LOAD_MAX   = 2'd1;
  localparam logic [1:0] CMD_LOAD_AVAIL = 2'd2;
  localparam logic [1:0] CMD_RUN        = 2'd3;

  // Configuration register indexes
  localparam logic CFG_NUM_PROCS = 1'b0;
  localparam logic CFG_NUM_RES   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SKIP,
    ST_WAIT,
    ST_EVAL,
    ST_COMMIT,
    ST_PASS_END,
    ST_OUT_SAFE,
    ST_OUT_UNSAFE
  } state_t;

  typedef struct packed {
    logic load;       // store the accepted load request
    logic init;       // start a run
    logic next_res;   // step resource column
    logic capture;    // latch allocation entry of the current column
    logic next_proc;  // step process row
    logic commit;     // release allocation, append to sequence
    logic restart;    // start another pass
    logic next_out;   // step output position
  } dp_cmd_t;

  typedef struct packed {
    logic proc_done;  // current process already finished
    logic fit;        // need of current column fits working vector
    logic res_last;   // current column is the last in use
    logic proc_last;  // current row is the last in use
    logic all_done;   // every process finished
    logic progress;   // this pass finished a process
    logic out_last;   // output position is the final one
  } dp_sts_t;

endpackage

>>> hw/rtl/bsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bsc_ctrl.sv
// Sequencer for loads, the safety scan and result output.
module bsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  input  logic              out_ready,
  input  bsc_pkg::dp_sts_t  sts,
  output bsc_pkg::dp_cmd_t  cmd,
  output logic              in_ready,
  output logic              out_valid,
  output logic              out_safe,
  output logic              out_last
);

  bsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bsc_pkg::ST_IDLE: begin
        if (in_valid && in_cmd == bsc_pkg::CMD_RUN) state_next = bsc_pkg::ST_INIT;
      end
      bsc_pkg::ST_INIT: state_next = bsc_pkg::ST_SKIP;
      bsc_pkg::ST_SKIP: begin
        if (!sts.proc_done) state_next = bsc_pkg::ST_WAIT;
        else if (sts.proc_last) state_next = bsc_pkg::ST_PASS_END;
      end
      bsc_pkg::ST_WAIT: state_next = bsc_pkg::ST_EVAL;
      bsc_pkg::ST_EVAL: begin
        if (!sts.fit) begin
          state_next = sts.proc_last ? bsc_pkg::ST_PASS_END : bsc_pkg::ST_SKIP;
        end else if (sts.res_last) begin
          state_next = bsc_pkg::ST_COMMIT;
        end else begin
          state_next = bsc_pkg::ST_WAIT;
        end
      end
      bsc_pkg::ST_COMMIT: begin
        state_next = sts.proc_last ? bsc_pkg::ST_PASS_END : bsc_pkg::ST_SKIP;
      end
      bsc_pkg::ST_PASS_END: begin
        if (sts.all_done) state_next = bsc_pkg::ST_OUT_SAFE;
        else if (!sts.progress) state_next = bsc_pkg::ST_OUT_UNSAFE;
        else state_next = bsc_pkg::ST_SKIP;
      end
      bsc_pkg::ST_OUT_SAFE: begin
        if (out_ready && sts.out_last) state_next = bsc_pkg::ST_IDLE;
      end
      bsc_pkg::ST_OUT_UNSAFE: begin
        if (out_ready) state_next = bsc_pkg::ST_IDLE;
      end
      default: state_next = bsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_safe  = 1'b0;
    out_last  = 1'b0;
    case (state)
      bsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && in_cmd != bsc_pkg::CMD_RUN;
      end
      bsc_pkg::ST_INIT: cmd.init = 1'b1;
      bsc_pkg::ST_SKIP: cmd.next_proc = sts.proc_done && !sts.proc_last;
      bsc_pkg::ST_WAIT: ;
      bsc_pkg::ST_EVAL: begin
        cmd.capture   = 1'b1;
        cmd.next_res  = sts.fit && !sts.res_last;
        cmd.next_proc = !sts.fit && !sts.proc_last;
      end
      bsc_pkg::ST_COMMIT: begin
        cmd.commit    = 1'b1;
        cmd.next_proc = !sts.proc_last;
      end
      bsc_pkg::ST_PASS_END: cmd.restart = !sts.all_done && sts.progress;
      bsc_pkg::ST_OUT_SAFE: begin
        out_valid    = 1'b1;
        out_safe     = 1'b1;
        out_last     = sts.out_last;
        cmd.next_out = out_ready;
      end
      bsc_pkg::ST_OUT_UNSAFE: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/bsc_dp.sv
// Datapath: matrix stores, working vector, finish flags and safe sequence.
module bsc_dp #(
  parameter int unsigned MAX_PROCS  = bsc_pkg::MAX_PROCS_DEF,
  parameter int unsigned MAX_RES    = bsc_pkg::MAX_RES_DEF,
  parameter int unsigned VALUE_BITS = bsc_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bsc_pkg::dp_cmd_t  cmd,
  output bsc_pkg::dp_sts_t  sts,
  input  logic [1:0]        in_cmd,
  input  logic [3:0]        in_proc,
  input  logic [2:0]        in_res,
  input  logic [15:0]       in_value,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data,
  output logic [3:0]        out_proc
);

  localparam int unsigned DEPTH = MAX_PROCS * MAX_RES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int unsigned NPW   = $clog2(MAX_PROCS + 1);
  localparam int unsigned NRW   = $clog2(MAX_RES + 1);
  localparam int unsigned WB    = VALUE_BITS + $clog2(MAX_PROCS + 1);

  logic [4:0]            num_procs;
  logic [3:0]            num_res;
  logic [NPW-1:0]        np_eff;
  logic [NRW-1:0]        nr_eff;
  logic [VALUE_BITS-1:0] avail_loaded [MAX_RES];
  logic [WB-1:0]         avail_work   [MAX_RES];
  logic [VALUE_BITS-1:0] row          [MAX_RES];
  logic [MAX_PROCS-1:0]  finished;
  logic [PW-1:0]         seq          [MAX_PROCS];
  logic [NPW-1:0]        done_count;
  logic                  progress;
  logic [PW-1:0]         p;
  logic [RW-1:0]         r;
  logic [PW-1:0]         k;
  logic [VALUE_BITS-1:0] alloc_rd, max_rd, need;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wvalue;
  logic                  in_range;

  // Effective counts: zero acts as one, saturate at the maximum.
  always_comb begin
    if (num_procs == '0) np_eff = NPW'(1);
    else if (int'(num_procs) > MAX_PROCS) np_eff = NPW'(MAX_PROCS);
    else np_eff = NPW'(num_procs);
    if (num_res == '0) nr_eff = NRW'(1);
    else if (int'(num_res) > MAX_RES) nr_eff = NRW'(MAX_RES);
    else nr_eff = NRW'(num_res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_procs <= 5'd1;
      num_res   <= 4'd1;
    end else if (cfg_we) begin
      if (cfg_index == bsc_pkg::CFG_NUM_PROCS) num_procs <= cfg_data;
      else num_res <= cfg_data[3:0];
    end
  end

  assign in_range = (int'(in_proc) < MAX_PROCS) && (int'(in_res) < MAX_RES);
  assign waddr    = AW'(int'(in_proc) * MAX_RES + int'(in_res));
  assign raddr    = AW'(int'(p) * MAX_RES + int'(r));
  assign wvalue   = VALUE_BITS'(in_value);

  bsc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_alloc (
    .clk(clk), .we(cmd.load && in_range && in_cmd == bsc_pkg::CMD_LOAD_ALLOC),
    .waddr(waddr), .wdata(wvalue), .raddr(raddr), .rdata(alloc_rd)
  );

  bsc_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_max (
    .clk(clk), .we(cmd.load && in_range && in_cmd == bsc_pkg::CMD_LOAD_MAX),
    .waddr(waddr), .wdata(wvalue), .raddr(raddr), .rdata(max_rd)
  );

  assign need = max_rd - alloc_rd;

  always_comb begin
    sts.proc_done = finished[p];
    sts.fit       = (max_rd <= alloc_rd) || (WB'(need) <= avail_work[r]);
    sts.res_last  = (NRW'(r) + NRW'(1)) == nr_eff;
    sts.proc_last = (NPW'(p) + NPW'(1)) == np_eff;
    sts.all_done  = done_count == np_eff;
    sts.progress  = progress;
    sts.out_last  = (NPW'(k) + NPW'(1)) == np_eff;
  end

  assign out_proc = 4'(seq[k]);

  always_ff @(posedge clk) begin
    if (rst) begin
      finished   <= '0;
      done_count <= '0;
      progress   <= 1'b0;
      p          <= '0;
      r          <= '0;
      k          <= '0;
      for (int i = 0; i < MAX_RES; i++) begin
        avail_loaded[i] <= '0;
        avail_work[i]   <= '0;
      end
      for (int i = 0; i < MAX_PROCS; i++) seq[i] <= '0;
    end else begin
      if (cmd.load && in_cmd == bsc_pkg::CMD_LOAD_AVAIL && int'(in_res) < MAX_RES) begin
        avail_loaded[RW'(in_res)] <= wvalue;
      end
      if (cmd.init) begin
        for (int i = 0; i < MAX_RES; i++) avail_work[i] <= WB'(avail_loaded[i]);
        finished   <= '0;
        done_count <= '0;
      end
      if (cmd.init || cmd.restart) begin
        progress <= 1'b0;
        p        <= '0;
        r        <= '0;
        k        <= '0;
      end
      if (cmd.capture) row[r] <= alloc_rd;
      if (cmd.next_res) r <= r + RW'(1);
      if (cmd.next_proc) begin
        p <= p + PW'(1);
        r <= '0;
      end
      if (cmd.commit) begin
        for (int i = 0; i < MAX_RES; i++) begin
          if (i < int'(nr_eff)) avail_work[i] <= avail_work[i] + WB'(row[i]);
        end
        seq[PW'(done_count)] <= p;
        done_count           <= done_count + NPW'(1);
        finished[p]          <= 1'b1;
        progress             <= 1'b1;
      end
      if (cmd.next_out) k <= k + PW'(1);
    end
  end

endmodule

>>> hw/rtl/bankers_safety_check.sv
// Top level of the banker's algorithm safety check block.
//
// Requests arrive on the s_* stream: s_tuser carries the command (load
// allocation, load maximum, load available, run check), s_tdata the row,
// column and unit count. Each load is accepted while idle and yields no result.
// A run request starts the scan; s_tready stays low until its results are
// all delivered. Per candidate process the scan tests its finish flag, then
// reads and compares each resource column in turn (RAM read, compare), and
// releases its allocation when every column fits; a pass ends with a check
// for completion or progress. At worst the scan runs num_procs passes, its
// pace set by the single read port of the allocation and maximum RAMs.
// Results leave on the m_* stream: m_tuser is the safe flag, m_tdata the
// process id, m_tlast marks the final result. A safe run gives num_procs
// results in sequence order; an unsafe run gives one result with id 0.
// When m_tready is low the result holds and the block waits.
// Reset (rst, synchronous) clears the available vector, flags, sequence and counts
// and sets both counts to one; matrix contents stay undefined. The user must write
// configuration (cfg_we/cfg_index/cfg_data) only while idle; the block does not check it.
module bankers_safety_check #(
  parameter int unsigned MAX_PROCS  = bsc_pkg::MAX_PROCS_DEF,
  parameter int unsigned MAX_RES    = bsc_pkg::MAX_RES_DEF,
  parameter int unsigned VALUE_BITS = bsc_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // proc_index[3:0], res_index[6:4], value[22:7], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // proc_id[3:0], zero pad
  output logic        m_tuser,   // safe
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  bsc_pkg::dp_cmd_t cmd;
  bsc_pkg::dp_sts_t sts;
  logic [3:0]       out_proc;
  logic             out_safe;

  bsc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_cmd(s_tuser), .out_ready(m_tready),
    .sts(sts), .cmd(cmd),
    .in_ready(s_tready), .out_valid(m_tvalid), .out_safe(out_safe), .out_last(m_tlast)
  );

  bsc_dp #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_cmd(s_tuser), .in_proc(s_tdata[3:0]), .in_res(s_tdata[6:4]),
    .in_value(s_tdata[22:7]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_proc(out_proc)
  );

  // Unsafe result always reports process 0.
  assign m_tuser = out_safe;
  assign m_tdata = {4'b0, out_safe ? out_proc : 4'b0};

  // Input and output never open together: one run at a time.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input open while result pending");

  // An unsafe result is a lone final result with id 0.
  a_unsafe_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'd0))
    else $error("malformed unsafe result");

  // A run request closes the input side.
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == bsc_pkg::CMD_RUN) |=> !s_tready)
    else $error("input still open after run request");

  // Delivery of the final result reopens the input side.
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not reopened after final result");

endmodule
